[src/postfix_stack_evaluator_assert.svh]
// Assertion macros for the postfix stack evaluator
`ifndef POSTFIX_STACK_EVALUATOR_ASSERT_SVH
`define POSTFIX_STACK_EVALUATOR_ASSERT_SVH

`ifndef SYNTHESIS

`define PSE_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define PSE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define PSE_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)

`define PSE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

[src/pse_pkg.sv]
package pse_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int FRAC_BITS   = 16;
   localparam int DATA_W      = 32;
   localparam int MODE_W      = 3;
   localparam int ERR_W       = 2;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
   localparam int NUM_W       = DATA_W + FRAC_BITS;
   localparam int MAG_W       = 2 * DATA_W;
   localparam int DIV_CNT_W   = $clog2(NUM_W + 1);
   localparam int REQ_TDATA_W = ((MODE_W + DATA_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((DATA_W + ERR_W + 7) / 8) * 8;

   localparam logic [MODE_W-1:0] MODE_PUSH = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ADD  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SUB  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_MUL  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DIV  = 3'd4;

   localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
   localparam logic [ERR_W-1:0] ERR_UNDER = 2'd1;
   localparam logic [ERR_W-1:0] ERR_OVER  = 2'd2;
   localparam logic [ERR_W-1:0] ERR_DIVZ  = 2'd3;

   typedef struct packed {
      logic             load;
      logic             push;
      logic             flag_en;
      logic [ERR_W-1:0] flag_code;
      logic             addsub;
      logic             div_zero;
      logic             mul_cap;
      logic             mul_round;
      logic             div_start;
      logic             div_round;
      logic             saturate;
      logic             writeback;
      logic             emit;
   } cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              last;
      logic              full;
      logic              lt2;
      logic              right_zero;
      logic              div_busy;
      logic              out_busy;
   } status_type;

endpackage

[src/pse_ram.sv]
module pse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/pse_div.sv]
module pse_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pse_pkg::DATA_W-1:0]    dividend,
   input  logic [pse_pkg::DATA_W-1:0]    divisor,
   output logic                          busy,
   output logic [pse_pkg::NUM_W-1:0]     quotient,
   output logic [pse_pkg::DATA_W-1:0]    remainder
);

   logic [pse_pkg::NUM_W-1:0]     num_ff, num_in;
   logic [pse_pkg::DATA_W-1:0]    rem_ff, rem_in;
   logic [pse_pkg::DATA_W-1:0]    den_ff, den_in;
   logic [pse_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic [pse_pkg::DATA_W:0]      trial;
   logic [pse_pkg::DATA_W:0]      diff;
   logic                          ge;

   always_comb begin
      trial = {rem_ff, num_ff[pse_pkg::NUM_W-1]};
      diff  = trial - {1'b0, den_ff};
      ge    = trial >= {1'b0, den_ff};
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         num_in  = pse_pkg::NUM_W'(dividend) << pse_pkg::FRAC_BITS;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = pse_pkg::DIV_CNT_W'(pse_pkg::NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[pse_pkg::NUM_W-2:0], ge};
         rem_in = ge ? diff[pse_pkg::DATA_W-1:0] : trial[pse_pkg::DATA_W-1:0];
         cnt_in = cnt_ff - pse_pkg::DIV_CNT_W'(1);
         if (cnt_ff == pse_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy      = busy_ff;
   assign quotient  = num_ff;
   assign remainder = rem_ff;

endmodule

[src/pse_dp.sv]
module pse_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  pse_pkg::cmd_type              cmd,
   output pse_pkg::status_type           status,
   input  logic [pse_pkg::MODE_W-1:0]    tok_mode,
   input  logic [pse_pkg::DATA_W-1:0]    tok_operand,
   input  logic                          tok_last,
   input  logic                          rsp_tready,
   output logic                          rsp_tvalid,
   output logic [pse_pkg::DATA_W-1:0]    rsp_result,
   output logic [pse_pkg::ERR_W-1:0]     rsp_error
);

   localparam logic [pse_pkg::DATA_W-1:0] MAX_VAL = {1'b0, {(pse_pkg::DATA_W-1){1'b1}}};
   localparam logic [pse_pkg::DATA_W-1:0] MIN_VAL = {1'b1, {(pse_pkg::DATA_W-1){1'b0}}};
   localparam logic [pse_pkg::MAG_W-1:0]  SAT_LIM = pse_pkg::MAG_W'(1) << (pse_pkg::DATA_W-1);
   localparam logic [pse_pkg::MAG_W-1:0]  MUL_HALF =
      (pse_pkg::MAG_W'(1) << pse_pkg::FRAC_BITS) >> 1;

   function automatic logic [pse_pkg::DATA_W-1:0] sat_mag(
      input logic [pse_pkg::MAG_W-1:0] m,
      input logic                      n
   );
      if (n) begin
         if (m >= SAT_LIM) return MIN_VAL;
         return pse_pkg::DATA_W'(0) - m[pse_pkg::DATA_W-1:0];
      end
      if (m >= SAT_LIM) return MAX_VAL;
      return m[pse_pkg::DATA_W-1:0];
   endfunction

   logic [pse_pkg::MODE_W-1:0]  mode_ff, mode_in;
   logic [pse_pkg::DATA_W-1:0]  operand_ff, operand_in;
   logic                        last_ff, last_in;
   logic [pse_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [pse_pkg::ERR_W-1:0]   sticky_ff, sticky_in;
   logic [pse_pkg::DATA_W-1:0]  top_ff, top_in;
   logic [pse_pkg::DATA_W-1:0]  result_ff, result_in;
   logic [pse_pkg::MAG_W-1:0]   prod_ff, prod_in;
   logic [pse_pkg::MAG_W-1:0]   mag_ff, mag_in;
   logic                        neg_ff, neg_in;
   logic                        out_valid_ff, out_valid_in;
   logic [pse_pkg::DATA_W-1:0]  out_value_ff, out_value_in;
   logic [pse_pkg::ERR_W-1:0]   out_error_ff, out_error_in;

   logic [pse_pkg::COUNT_W-1:0] below_top;
   logic [pse_pkg::DATA_W-1:0]  left;
   logic [pse_pkg::DATA_W:0]    sum;
   logic [pse_pkg::DATA_W-1:0]  mag_left, mag_right;
   logic [pse_pkg::MAG_W-1:0]   rounded;
   logic                        ram_we;
   logic [pse_pkg::ADDR_W-1:0]  ram_waddr;
   logic [pse_pkg::DATA_W-1:0]  ram_wdata;
   logic                        div_busy;
   logic [pse_pkg::NUM_W-1:0]   div_q;
   logic [pse_pkg::DATA_W-1:0]  div_r;
   logic                        div_up;

   assign below_top = count_ff - pse_pkg::COUNT_W'(2);

   pse_ram #(
      .WIDTH (pse_pkg::DATA_W),
      .DEPTH (pse_pkg::STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (below_top[pse_pkg::ADDR_W-1:0]),
      .rd_data (left)
   );

   assign mag_left  = left[pse_pkg::DATA_W-1] ? pse_pkg::DATA_W'(0) - left : left;
   assign mag_right = top_ff[pse_pkg::DATA_W-1] ? pse_pkg::DATA_W'(0) - top_ff : top_ff;

   pse_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (mag_left),
      .divisor   (mag_right),
      .busy      (div_busy),
      .quotient  (div_q),
      .remainder (div_r)
   );

   always_comb begin
      ram_we    = cmd.push || cmd.writeback;
      ram_waddr = cmd.writeback ? below_top[pse_pkg::ADDR_W-1:0]
                                : count_ff[pse_pkg::ADDR_W-1:0];
      ram_wdata = cmd.writeback ? result_ff : operand_ff;
   end

   always_comb begin
      if (mode_ff == pse_pkg::MODE_SUB) begin
         sum = {left[pse_pkg::DATA_W-1], left} - {top_ff[pse_pkg::DATA_W-1], top_ff};
      end else begin
         sum = {left[pse_pkg::DATA_W-1], left} + {top_ff[pse_pkg::DATA_W-1], top_ff};
      end
      rounded = prod_ff[pse_pkg::MAG_W-1] ? MUL_HALF - prod_ff : prod_ff + MUL_HALF;
      div_up  = {div_r, 1'b0} >= {1'b0, mag_right};
   end

   always_comb begin
      mode_in      = mode_ff;
      operand_in   = operand_ff;
      last_in      = last_ff;
      count_in     = count_ff;
      sticky_in    = sticky_ff;
      top_in       = top_ff;
      result_in    = result_ff;
      prod_in      = prod_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      out_valid_in = out_valid_ff;
      out_value_in = out_value_ff;
      out_error_in = out_error_ff;

      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end

      if (cmd.load) begin
         mode_in    = tok_mode;
         operand_in = tok_operand;
         last_in    = tok_last;
      end

      if (cmd.flag_en && sticky_ff == pse_pkg::ERR_NONE) begin
         sticky_in = cmd.flag_code;
      end

      if (cmd.push) begin
         count_in = count_ff + pse_pkg::COUNT_W'(1);
         top_in   = operand_ff;
      end

      if (cmd.addsub) begin
         if (sum[pse_pkg::DATA_W] != sum[pse_pkg::DATA_W-1]) begin
            result_in = sum[pse_pkg::DATA_W] ? MIN_VAL : MAX_VAL;
         end else begin
            result_in = sum[pse_pkg::DATA_W-1:0];
         end
      end

      if (cmd.div_zero) begin
         if (left[pse_pkg::DATA_W-1]) begin
            result_in = MIN_VAL;
         end else if (left == '0) begin
            result_in = '0;
         end else begin
            result_in = MAX_VAL;
         end
      end

      if (cmd.mul_cap) begin
         prod_in = pse_pkg::MAG_W'($signed(left)) * pse_pkg::MAG_W'($signed(top_ff));
      end

      if (cmd.mul_round) begin
         mag_in = rounded >> pse_pkg::FRAC_BITS;
         neg_in = prod_ff[pse_pkg::MAG_W-1];
      end

      if (cmd.div_start) begin
         neg_in = left[pse_pkg::DATA_W-1] ^ top_ff[pse_pkg::DATA_W-1];
      end

      if (cmd.div_round) begin
         mag_in = pse_pkg::MAG_W'(div_q) + pse_pkg::MAG_W'(div_up);
      end

      if (cmd.saturate) begin
         result_in = sat_mag(mag_ff, neg_ff);
      end

      if (cmd.writeback) begin
         count_in = count_ff - pse_pkg::COUNT_W'(1);
         top_in   = result_ff;
      end

      if (cmd.emit) begin
         out_valid_in = 1'b1;
         if (count_ff == '0) begin
            out_value_in = '0;
            out_error_in = (sticky_ff == pse_pkg::ERR_NONE) ? pse_pkg::ERR_UNDER : sticky_ff;
         end else begin
            out_value_in = top_ff;
            out_error_in = sticky_ff;
         end
         count_in  = '0;
         sticky_in = pse_pkg::ERR_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         sticky_ff    <= pse_pkg::ERR_NONE;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         sticky_ff    <= sticky_in;
         out_valid_ff <= out_valid_in;
      end
      mode_ff      <= mode_in;
      operand_ff   <= operand_in;
      last_ff      <= last_in;
      top_ff       <= top_in;
      result_ff    <= result_in;
      prod_ff      <= prod_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      out_value_ff <= out_value_in;
      out_error_ff <= out_error_in;
   end

   always_comb begin
      status.mode       = mode_ff;
      status.last       = last_ff;
      status.full       = count_ff == pse_pkg::COUNT_W'(pse_pkg::STACK_DEPTH);
      status.lt2        = count_ff < pse_pkg::COUNT_W'(2);
      status.right_zero = top_ff == '0;
      status.div_busy   = div_busy;
      status.out_busy   = out_valid_ff && !rsp_tready;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_result = out_value_ff;
   assign rsp_error  = out_error_ff;

endmodule

[src/pse_ctrl.sv]
module pse_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  pse_pkg::status_type status,
   output pse_pkg::cmd_type    cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_CALC   = 4'd2;
   localparam logic [3:0] S_MROUND = 4'd3;
   localparam logic [3:0] S_DIVW   = 4'd4;
   localparam logic [3:0] S_DROUND = 4'd5;
   localparam logic [3:0] S_SAT    = 4'd6;
   localparam logic [3:0] S_WB     = 4'd7;
   localparam logic [3:0] S_END    = 4'd8;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_END;
            case (status.mode)
               pse_pkg::MODE_PUSH: begin
                  if (status.full) begin
                     cmd.flag_en   = 1'b1;
                     cmd.flag_code = pse_pkg::ERR_OVER;
                  end else begin
                     cmd.push = 1'b1;
                  end
               end
               pse_pkg::MODE_ADD, pse_pkg::MODE_SUB,
               pse_pkg::MODE_MUL, pse_pkg::MODE_DIV: begin
                  if (status.lt2) begin
                     cmd.flag_en   = 1'b1;
                     cmd.flag_code = pse_pkg::ERR_UNDER;
                  end else begin
                     state_in = S_CALC;
                  end
               end
               default: begin
                  state_in = S_END;
               end
            endcase
         end
         S_CALC: begin
            case (status.mode)
               pse_pkg::MODE_MUL: begin
                  cmd.mul_cap = 1'b1;
                  state_in    = S_MROUND;
               end
               pse_pkg::MODE_DIV: begin
                  if (status.right_zero) begin
                     cmd.flag_en   = 1'b1;
                     cmd.flag_code = pse_pkg::ERR_DIVZ;
                     cmd.div_zero  = 1'b1;
                     state_in      = S_WB;
                  end else begin
                     cmd.div_start = 1'b1;
                     state_in      = S_DIVW;
                  end
               end
               default: begin
                  cmd.addsub = 1'b1;
                  state_in   = S_WB;
               end
            endcase
         end
         S_MROUND: begin
            cmd.mul_round = 1'b1;
            state_in      = S_SAT;
         end
         S_DIVW: begin
            if (!status.div_busy) begin
               state_in = S_DROUND;
            end
         end
         S_DROUND: begin
            cmd.div_round = 1'b1;
            state_in      = S_SAT;
         end
         S_SAT: begin
            cmd.saturate = 1'b1;
            state_in     = S_WB;
         end
         S_WB: begin
            cmd.writeback = 1'b1;
            state_in      = S_END;
         end
         S_END: begin
            if (!status.last) begin
               state_in = S_IDLE;
            end else if (!status.out_busy) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[src/postfix_stack_evaluator.sv]
// Postfix (RPN) evaluator on signed fixed-point values with pse_pkg::FRAC_BITS fraction
// bits, one token per req beat, one result beat per token that carries tlast. Tokens are
// taken one at a time: the next beat is accepted only once the current token is done, and
// a divide waits on the bit-serial restoring divider that retires one quotient bit per
// cycle. Every operator reads its left operand from the stack RAM while the right operand
// is kept in a top-of-stack register. A finished result sits in an output register, so
// tokens of the next expression are accepted while it waits; a last token whose result
// finds that register still occupied holds until the previous beat is taken. Errors are
// sticky per expression and clear with the result beat.
`include "postfix_stack_evaluator_assert.svh"

module postfix_stack_evaluator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // mode [2:0], operand_value [34:3], zero pad
   input  logic [pse_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // result_value [31:0], error_code [33:32], zero pad
   output logic [pse_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   pse_pkg::cmd_type              cmd;
   pse_pkg::status_type           status;
   logic [pse_pkg::DATA_W-1:0]    rsp_result;
   logic [pse_pkg::ERR_W-1:0]     rsp_error;

   pse_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pse_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .tok_mode    (req_tdata[pse_pkg::MODE_W-1:0]),
      .tok_operand (req_tdata[pse_pkg::MODE_W +: pse_pkg::DATA_W]),
      .tok_last    (req_tlast),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_result  (rsp_result),
      .rsp_error   (rsp_error)
   );

   assign rsp_tdata = pse_pkg::RSP_TDATA_W'({rsp_error, rsp_result});

   `PSE_ASSERT_SAME(a_emit_slot_free, clock, reset, cmd.emit, !status.out_busy, "result lost")
   `PSE_ASSERT_NEXT(a_one_token, clock, reset, req_tvalid && req_tready, !req_tready, "re-accept")
   `PSE_ASSERT_NEXT(a_div_runs, clock, reset, cmd.div_start, status.div_busy, "divider idle")
   `PSE_ASSERT_SAME(a_wb_two_operands, clock, reset, cmd.writeback, !status.lt2, "wb underflow")

endmodule

[tb/postfix_stack_evaluator_checker.sv]
module postfix_stack_evaluator_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   // mode [2:0], operand_value [34:3], zero pad
   input  logic [pse_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                            req_tlast,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // result_value [31:0], error_code [33:32], zero pad
   input  logic [pse_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output int                              fail_count,
   output int                              pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint MAX_Q = 64'sd2147483647;
   localparam longint MIN_Q = -64'sd2147483648;

   typedef struct packed {
      logic [pse_pkg::ERR_W-1:0]  code;
      logic [pse_pkg::DATA_W-1:0] value;
   } outcome_type;

   logic signed [pse_pkg::DATA_W-1:0] operand_stack [pse_pkg::STACK_DEPTH];
   int                                depth = 0;
   logic [pse_pkg::ERR_W-1:0]         first_error = pse_pkg::ERR_NONE;
   outcome_type                       outcome_q[$];
   int                                mismatches = 0;
   int                                outstanding = 0;

   assign fail_count = mismatches;
   assign pending    = outstanding;

   function automatic longint unsigned magnitude(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   function automatic logic [pse_pkg::DATA_W-1:0] clamp(longint v);
      if (v > MAX_Q) return 32'h7FFF_FFFF;
      if (v < MIN_Q) return 32'h8000_0000;
      return v[pse_pkg::DATA_W-1:0];
   endfunction

   function automatic logic [pse_pkg::DATA_W-1:0] signed_clamp(longint unsigned m,
                                                               bit negative);
      if (negative) begin
         if (m >= 64'd2147483648) return 32'h8000_0000;
         return clamp(-longint'(m));
      end
      if (m > 64'd2147483647) return 32'h7FFF_FFFF;
      return m[pse_pkg::DATA_W-1:0];
   endfunction

   // round half away from zero
   function automatic logic [pse_pkg::DATA_W-1:0] q_multiply(longint a, longint b);
      longint          product;
      longint unsigned m;
      product = a * b;
      m = magnitude(product);
      if (pse_pkg::FRAC_BITS > 0)
         m = (m + (64'd1 << (pse_pkg::FRAC_BITS - 1))) >> pse_pkg::FRAC_BITS;
      return signed_clamp(m, product < 0);
   endfunction

   function automatic logic [pse_pkg::DATA_W-1:0] q_divide(longint a, longint b);
      longint unsigned n, d, q;
      n = magnitude(a) << pse_pkg::FRAC_BITS;
      d = magnitude(b);
      q = (64'd2 * n + d) / (64'd2 * d);
      return signed_clamp(q, (a < 0) != (b < 0));
   endfunction

   function automatic void note_error(logic [pse_pkg::ERR_W-1:0] code);
      if (first_error == pse_pkg::ERR_NONE) first_error = code;
   endfunction

   task automatic apply_token(logic [pse_pkg::MODE_W-1:0] mode,
                              logic [pse_pkg::DATA_W-1:0] operand, logic last);
      longint                     lhs, rhs;
      logic [pse_pkg::DATA_W-1:0] folded;
      outcome_type                done;
      if (mode == pse_pkg::MODE_PUSH) begin
         if (depth < pse_pkg::STACK_DEPTH) begin
            operand_stack[depth] = operand;
            depth++;
         end else begin
            note_error(pse_pkg::ERR_OVER);
         end
      end else if (mode >= pse_pkg::MODE_ADD && mode <= pse_pkg::MODE_DIV) begin
         if (depth < 2) begin
            note_error(pse_pkg::ERR_UNDER);
         end else begin
            rhs = operand_stack[depth-1];
            lhs = operand_stack[depth-2];
            case (mode)
               pse_pkg::MODE_ADD: folded = clamp(lhs + rhs);
               pse_pkg::MODE_SUB: folded = clamp(lhs - rhs);
               pse_pkg::MODE_MUL: folded = q_multiply(lhs, rhs);
               default: begin
                  if (rhs == 0) begin
                     note_error(pse_pkg::ERR_DIVZ);
                     folded = (lhs > 0) ? 32'h7FFF_FFFF : ((lhs < 0) ? 32'h8000_0000 : '0);
                  end else begin
                     folded = q_divide(lhs, rhs);
                  end
               end
            endcase
            depth--;
            operand_stack[depth-1] = folded;
         end
      end
      if (last) begin
         if (depth == 0) begin
            note_error(pse_pkg::ERR_UNDER);
            done.value = '0;
         end else begin
            done.value = operand_stack[depth-1];
         end
         done.code = first_error;
         outcome_q.push_back(done);
         depth = 0;
         first_error = pse_pkg::ERR_NONE;
      end
   endtask

   always @(posedge clock) begin : monitor
      outcome_type seen, want;
      if (reset) begin
         depth = 0;
         first_error = pse_pkg::ERR_NONE;
         outcome_q.delete();
      end else begin
         // retire results before this edge's token can add a new one
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata[pse_pkg::DATA_W+pse_pkg::ERR_W-1:0];
            if (outcome_q.size() == 0) begin
               $error("unexpected rsp beat: result_value %h error_code %0d",
                      seen.value, seen.code);
               mismatches++;
            end else begin
               want = outcome_q.pop_front();
               if (seen.value !== want.value) begin
                  $error("result_value expected %h actual %h", want.value, seen.value);
                  mismatches++;
               end
               if (seen.code !== want.code) begin
                  $error("error_code expected %0d actual %0d", want.code, seen.code);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready)
            apply_token(req_tdata[pse_pkg::MODE_W-1:0],
                        req_tdata[pse_pkg::MODE_W +: pse_pkg::DATA_W], req_tlast);
      end
      outstanding <= outcome_q.size();
   end

endmodule

[tb/postfix_stack_evaluator_test.sv]
module postfix_stack_evaluator_test;
   timeunit 1ns;
   timeprecision 1ps;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [pse_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic                            req_tlast = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [pse_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   int                              fail_count;
   int                              pending;

   int tokens_sent = 0;
   bit steady = 1'b0;
   bit hold_rsp = 1'b0;

   always #6 clock = ~clock;

   postfix_stack_evaluator dut (.*);

   postfix_stack_evaluator_checker checker_i (.*);

   initial begin
      #10_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic int gap_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   function automatic logic [pse_pkg::DATA_W-1:0] pick_operand();
      logic [pse_pkg::DATA_W-1:0] extremes [6] = '{32'h7FFF_FFFF, 32'h8000_0000,
                                                  32'h0000_0001, 32'hFFFF_FFFF,
                                                  32'h0001_0000, 32'hFFFF_0000};
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return extremes[$urandom_range(0, 5)];
         2, 3, 4: return pse_pkg::DATA_W'(($urandom_range(0, 200) - 100)
                                          <<< pse_pkg::FRAC_BITS);
         5, 6:    return pse_pkg::DATA_W'(int'($urandom_range(0, 2097152)) - 1048576);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_token(logic [pse_pkg::MODE_W-1:0] mode,
                             logic [pse_pkg::DATA_W-1:0] value, logic last);
      logic [pse_pkg::REQ_TDATA_W-1:0] beat;
      int                              gap;
      beat = '0;
      beat[pse_pkg::MODE_W-1:0] = mode;
      beat[pse_pkg::MODE_W +: pse_pkg::DATA_W] = value;
      req_tvalid <= 1'b1;
      req_tdata  <= beat;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      if (mode <= pse_pkg::MODE_DIV) tokens_sent++;
      gap = steady ? 0 : gap_cycles();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_expression(int operands);
      int   remaining, depth_now;
      logic last;
      remaining = operands;
      depth_now = 0;
      while (remaining > 0 || depth_now > 1) begin
         if (depth_now >= 2 && (remaining == 0 || $urandom_range(0, 1) == 1)) begin
            depth_now--;
            last = (remaining == 0 && depth_now == 1);
            send_token(pse_pkg::MODE_ADD + 3'($urandom_range(0, 3)), $urandom, last);
         end else begin
            remaining--;
            depth_now++;
            last = (remaining == 0 && depth_now == 1);
            send_token(pse_pkg::MODE_PUSH, pick_operand(), last);
         end
         if (!last && $urandom_range(0, 19) == 0)
            send_token(pse_pkg::MODE_DIV + 3'($urandom_range(1, 3)), $urandom, 1'b0);
      end
   endtask

   task automatic send_broken();
      case ($urandom_range(0, 4))
         0: begin
            repeat (pse_pkg::STACK_DEPTH + $urandom_range(1, 3))
               send_token(pse_pkg::MODE_PUSH, pick_operand(), 1'b0);
            send_token(pse_pkg::MODE_ADD + 3'($urandom_range(0, 3)), $urandom, 1'b1);
         end
         1: begin
            send_token(pse_pkg::MODE_ADD + 3'($urandom_range(0, 3)), $urandom, 1'b0);
            send_expression($urandom_range(1, 4));
         end
         2: send_token(pse_pkg::MODE_ADD + 3'($urandom_range(0, 3)), $urandom, 1'b1);
         3: send_token(pse_pkg::MODE_DIV + 3'($urandom_range(1, 3)), $urandom, 1'b1);
         default:
            repeat ($urandom_range(1, 6))
               send_token(3'($urandom), $urandom, $urandom_range(0, 3) == 0);
      endcase
   endtask

   initial begin
      int span;
      @(posedge clock iff !reset);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (600) @(posedge clock);
            hold_rsp = 1'b0;
         end else if ($urandom_range(0, 2) != 0) begin
            rsp_tready <= 1'b1;
            span = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
            repeat (span) @(posedge clock);
         end else begin
            rsp_tready <= 1'b0;
            span = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
            repeat (span) @(posedge clock);
         end
      end
   end

   initial begin
      int expressions;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // saturating add and subtract, product of two minimums
      send_token(pse_pkg::MODE_PUSH, 32'h7FFF_FFFF, 1'b0);
      send_token(pse_pkg::MODE_PUSH, 32'h0000_0001, 1'b0);
      send_token(pse_pkg::MODE_ADD, 32'h0, 1'b1);
      send_token(pse_pkg::MODE_PUSH, 32'h8000_0000, 1'b0);
      send_token(pse_pkg::MODE_PUSH, 32'h0000_0001, 1'b0);
      send_token(pse_pkg::MODE_SUB, 32'h0, 1'b1);
      send_token(pse_pkg::MODE_PUSH, 32'h8000_0000, 1'b0);
      send_token(pse_pkg::MODE_PUSH, 32'h8000_0000, 1'b0);
      send_token(pse_pkg::MODE_MUL, 32'h0, 1'b1);
      // divide by zero with positive and zero dividend, rounded quotient
      send_token(pse_pkg::MODE_PUSH, 32'h0007_0000, 1'b0);
      send_token(pse_pkg::MODE_PUSH, 32'h0, 1'b0);
      send_token(pse_pkg::MODE_DIV, 32'h0, 1'b1);
      send_token(pse_pkg::MODE_PUSH, 32'h0, 1'b0);
      send_token(pse_pkg::MODE_PUSH, 32'h0, 1'b0);
      send_token(pse_pkg::MODE_DIV, 32'h0, 1'b1);
      send_token(pse_pkg::MODE_PUSH, 32'hFFFB_0000, 1'b0);
      send_token(pse_pkg::MODE_PUSH, 32'h0002_0000, 1'b0);
      send_token(pse_pkg::MODE_DIV, 32'h0, 1'b1);
      // operator and unused mode on an empty stack
      send_token(pse_pkg::MODE_ADD, 32'hFFFF_FFFF, 1'b1);
      send_token(pse_pkg::MODE_DIV + 3'd1, 32'hFFFF_FFFF, 1'b1);
      send_token(pse_pkg::MODE_DIV + 3'd3, 32'hFFFF_FFFF, 1'b0);
      send_token(pse_pkg::MODE_PUSH, 32'hFFFF_FFFF, 1'b1);
      // keep the first error when a later one follows
      send_token(pse_pkg::MODE_MUL, 32'h0, 1'b0);
      send_token(pse_pkg::MODE_PUSH, 32'h0001_0000, 1'b0);
      send_token(pse_pkg::MODE_PUSH, 32'h0, 1'b0);
      send_token(pse_pkg::MODE_DIV, 32'h0, 1'b1);

      expressions = 0;
      while (tokens_sent < 2000) begin
         steady = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 4) == 0)
            send_broken();
         else
            send_expression(($urandom_range(0, 9) == 0) ?
                            $urandom_range(10, pse_pkg::STACK_DEPTH) : $urandom_range(1, 6));
         expressions++;
         if (expressions % 150 == 40) hold_rsp = 1'b1;
         if (expressions % 150 == 100) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
